FILE: rtl/assert_macros.svh
// Assertion helpers shared by paq_axis and pad_input_axis_qualifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define PAQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PAQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PAQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PAQ_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/paq_pkg.sv
package paq_pkg;

  localparam int CONFIRM_COUNT_DEF = 2;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [14:0] CENTER_LIMIT_RST  = 15'd8000;
  localparam logic [14:0] PRESS_LIMIT_RST   = 15'd24000;
  localparam logic [14:0] RELEASE_LIMIT_RST = 15'd18000;

  // Direction codes, two's complement
  localparam logic signed [1:0] DIR_NEG  = 2'sb11;
  localparam logic signed [1:0] DIR_NONE = 2'sb00;
  localparam logic signed [1:0] DIR_POS  = 2'sb01;

  // Pad button numbers used by the mask
  localparam logic [3:0] BTN_A      = 4'd0;
  localparam logic [3:0] BTN_B      = 4'd1;
  localparam logic [3:0] BTN_L      = 4'd4;
  localparam logic [3:0] BTN_R      = 4'd5;
  localparam logic [3:0] BTN_SELECT = 4'd6;
  localparam logic [3:0] BTN_START  = 4'd7;

  typedef enum logic [2:0] {
    REG_PAD_PRESENT   = 3'd0,
    REG_AXIS_ENABLE   = 3'd1,
    REG_AXIS_COUNT    = 3'd2,
    REG_BUTTON_COUNT  = 3'd3,
    REG_HAT_PRESENT   = 3'd4,
    REG_CENTER_LIMIT  = 3'd5,
    REG_PRESS_LIMIT   = 3'd6,
    REG_RELEASE_LIMIT = 3'd7
  } paq_reg_t;

  typedef struct packed {
    logic        pad_present;
    logic        axis_enable;
    logic [1:0]  axis_count;
    logic [3:0]  button_count;
    logic        hat_present;
    logic [14:0] center_limit;
    logic [14:0] press_limit;
    logic [14:0] release_limit;
  } paq_cfg_t;

endpackage

FILE: rtl/paq_cfg.sv
module paq_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [paq_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [paq_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [paq_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output paq_pkg::paq_cfg_t               cfg_o
);

  paq_pkg::paq_cfg_t cfg_r, cfg_nxt;
  paq_pkg::paq_reg_t idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = paq_pkg::paq_reg_t'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        paq_pkg::REG_PAD_PRESENT:   cfg_nxt.pad_present   = pwdata[0];
        paq_pkg::REG_AXIS_ENABLE:   cfg_nxt.axis_enable   = pwdata[0];
        paq_pkg::REG_AXIS_COUNT:    cfg_nxt.axis_count    = pwdata[1:0];
        paq_pkg::REG_BUTTON_COUNT:  cfg_nxt.button_count  = pwdata[3:0];
        paq_pkg::REG_HAT_PRESENT:   cfg_nxt.hat_present   = pwdata[0];
        paq_pkg::REG_CENTER_LIMIT:  cfg_nxt.center_limit  = pwdata[14:0];
        paq_pkg::REG_PRESS_LIMIT:   cfg_nxt.press_limit   = pwdata[14:0];
        paq_pkg::REG_RELEASE_LIMIT: cfg_nxt.release_limit = pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      paq_pkg::REG_PAD_PRESENT:   prdata = {31'd0, cfg_r.pad_present};
      paq_pkg::REG_AXIS_ENABLE:   prdata = {31'd0, cfg_r.axis_enable};
      paq_pkg::REG_AXIS_COUNT:    prdata = {30'd0, cfg_r.axis_count};
      paq_pkg::REG_BUTTON_COUNT:  prdata = {28'd0, cfg_r.button_count};
      paq_pkg::REG_HAT_PRESENT:   prdata = {31'd0, cfg_r.hat_present};
      paq_pkg::REG_CENTER_LIMIT:  prdata = {17'd0, cfg_r.center_limit};
      paq_pkg::REG_PRESS_LIMIT:   prdata = {17'd0, cfg_r.press_limit};
      paq_pkg::REG_RELEASE_LIMIT: prdata = {17'd0, cfg_r.release_limit};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{pad_present:   1'b0,
                 axis_enable:   1'b0,
                 axis_count:    2'd0,
                 button_count:  4'd0,
                 hat_present:   1'b0,
                 center_limit:  paq_pkg::CENTER_LIMIT_RST,
                 press_limit:   paq_pkg::PRESS_LIMIT_RST,
                 release_limit: paq_pkg::RELEASE_LIMIT_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

FILE: rtl/paq_axis.sv
`include "assert_macros.svh"

module paq_axis #(
  parameter int CONFIRM_COUNT = paq_pkg::CONFIRM_COUNT_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step_i,
  input  logic signed [15:0]      raw_i,
  input  logic [14:0]             center_limit_i,
  input  logic [14:0]             press_limit_i,
  input  logic [14:0]             release_limit_i,
  output logic signed [1:0]       dir_o
);

  localparam logic [1:0] CONFIRM_W = 2'(CONFIRM_COUNT);

  logic               armed_r, armed_nxt;
  logic signed [1:0]  held_r, held_nxt;
  logic signed [1:0]  cand_r, cand_nxt;
  logic [1:0]         cnt_r, cnt_nxt;

  logic signed [16:0] raw_ext, ctr, prs, rel;
  logic               in_band;
  logic signed [1:0]  prop;
  logic [1:0]         cnt_inc;

  assign raw_ext = {raw_i[15], raw_i};
  assign ctr     = $signed({2'b00, center_limit_i});
  assign prs     = $signed({2'b00, press_limit_i});
  assign rel     = $signed({2'b00, release_limit_i});
  assign in_band = (raw_ext > -ctr) && (raw_ext < ctr);

  // Proposed direction with press/release hysteresis
  always_comb begin
    prop = paq_pkg::DIR_NONE;
    if (held_r == paq_pkg::DIR_NEG) begin
      prop = (raw_ext < -rel) ? paq_pkg::DIR_NEG : paq_pkg::DIR_NONE;
    end else if (held_r == paq_pkg::DIR_POS) begin
      prop = (raw_ext > rel) ? paq_pkg::DIR_POS : paq_pkg::DIR_NONE;
    end else if (raw_ext < -prs) begin
      prop = paq_pkg::DIR_NEG;
    end else if (raw_ext > prs) begin
      prop = paq_pkg::DIR_POS;
    end
  end

  assign cnt_inc = (cnt_r == 2'd3) ? cnt_r : cnt_r + 2'd1;

  always_comb begin
    armed_nxt = armed_r;
    held_nxt  = held_r;
    cand_nxt  = cand_r;
    cnt_nxt   = cnt_r;
    if (!armed_r && !in_band) begin
      // drop everything until the stick has been centred once
      held_nxt = paq_pkg::DIR_NONE;
      cand_nxt = paq_pkg::DIR_NONE;
      cnt_nxt  = 2'd0;
    end else begin
      armed_nxt = 1'b1;
      if (prop != held_r) begin
        if (prop == cand_r) begin
          cnt_nxt = cnt_inc;
        end else begin
          cand_nxt = prop;
          cnt_nxt  = 2'd1;
        end
        if (cnt_nxt >= CONFIRM_W) begin
          held_nxt = prop;
          cnt_nxt  = 2'd0;
        end
      end else begin
        cand_nxt = prop;
        cnt_nxt  = 2'd0;
      end
    end
  end

  assign dir_o = held_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      held_r  <= paq_pkg::DIR_NONE;
      cand_r  <= paq_pkg::DIR_NONE;
      cnt_r   <= 2'd0;
    end else if (step_i) begin
      armed_r <= armed_nxt;
      held_r  <= held_nxt;
      cand_r  <= cand_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `PAQ_ASSERT_IMP(a_unarmed_idle, clk, rst_n, !armed_r,
                  held_r == paq_pkg::DIR_NONE && cand_r == paq_pkg::DIR_NONE && cnt_r == 2'd0)
  `PAQ_ASSERT_IMP(a_cnt_below_confirm, clk, rst_n, 1'b1, cnt_r < CONFIRM_W)
  `PAQ_ASSERT_NXT(a_change_clears_cnt, clk, rst_n, step_i && held_nxt != held_r,
                  cnt_r == 2'd0)
  `PAQ_ASSERT_IMP(a_held_legal, clk, rst_n, 1'b1, held_r != 2'sb10)

endmodule

FILE: rtl/pad_input_axis_qualifier.sv
// Pad input qualifier: each input transaction is one poll sample (keyboard
// keys, hat bits, pad buttons and two signed axis samples) and yields one
// result transaction holding the 10-bit button mask and the qualified axis
// directions. An axis counts only after it has once been seen inside the
// centre band; it then uses press/release hysteresis and takes a new
// direction only after CONFIRM_COUNT equal successive proposals. The block
// takes one transaction per clock cycle while the receiver keeps up; the
// axis state advances as a sample passes from input to result register.
// The user, not the block, must write configuration over the APB-style
// port at byte address 4*index only while no transaction is in flight.
`include "assert_macros.svh"

module pad_input_axis_qualifier #(
  parameter int CONFIRM_COUNT = paq_pkg::CONFIRM_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // tdata: key_states[10:0], hat_bits[14:11], pad_buttons[22:15],
  //        axis_x[38:23], axis_y[54:39], zero [55]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [paq_pkg::IN_DATA_W-1:0]   in_tdata,
  // tdata: button_mask[9:0], dir_x[11:10], dir_y[13:12], zero [15:14]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [paq_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [paq_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [paq_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [paq_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  paq_pkg::paq_cfg_t cfg;

  logic                           s1_valid_r, s1_valid_nxt;
  logic [paq_pkg::IN_DATA_W-1:0]  s1_data_r;
  logic                           out_valid_r, out_valid_nxt;
  logic [paq_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                           advance;

  logic [10:0]        keys;
  logic [3:0]         hat;
  logic [7:0]         btn;
  logic signed [15:0] raw_x, raw_y;
  logic               axes_on, eval_x, eval_y;
  logic signed [1:0]  qdir_x, qdir_y, dx, dy;
  logic [9:0]         mask;

  paq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg_o   (cfg)
  );

  // Advance the held sample whenever the result register is free or drains
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  assign keys  = s1_data_r[10:0];
  assign hat   = s1_data_r[14:11];
  assign btn   = s1_data_r[22:15];
  assign raw_x = s1_data_r[38:23];
  assign raw_y = s1_data_r[54:39];

  // An axis is evaluated only with a pad, axis mapping and enough axes
  assign axes_on = cfg.pad_present && cfg.axis_enable;
  assign eval_x  = axes_on && (cfg.axis_count > 2'd0);
  assign eval_y  = axes_on && (cfg.axis_count > 2'd1);

  paq_axis #(.CONFIRM_COUNT(CONFIRM_COUNT)) u_axis_x (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_i          (advance && eval_x),
    .raw_i           (raw_x),
    .center_limit_i  (cfg.center_limit),
    .press_limit_i   (cfg.press_limit),
    .release_limit_i (cfg.release_limit),
    .dir_o           (qdir_x)
  );

  paq_axis #(.CONFIRM_COUNT(CONFIRM_COUNT)) u_axis_y (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_i          (advance && eval_y),
    .raw_i           (raw_y),
    .center_limit_i  (cfg.center_limit),
    .press_limit_i   (cfg.press_limit),
    .release_limit_i (cfg.release_limit),
    .dir_o           (qdir_y)
  );

  assign dx = eval_x ? qdir_x : paq_pkg::DIR_NONE;
  assign dy = eval_y ? qdir_y : paq_pkg::DIR_NONE;

  // Merge keyboard, hat, axes and pad buttons into the mask
  always_comb begin
    mask    = keys[9:0] & 10'h0FF;
    mask[8] = keys[8];
    mask[9] = keys[9] | keys[10];
    if (cfg.pad_present) begin
      if (cfg.hat_present) begin
        mask[3:0] = mask[3:0] | hat;
      end
      if (cfg.axis_enable) begin
        mask[0] = mask[0] | (dx == paq_pkg::DIR_NEG);
        mask[1] = mask[1] | (dx == paq_pkg::DIR_POS);
        mask[2] = mask[2] | (dy == paq_pkg::DIR_NEG);
        mask[3] = mask[3] | (dy == paq_pkg::DIR_POS);
      end
      // a pad button numbered at or above the configured count reads as released
      mask[4] = mask[4] | (btn[0] && cfg.button_count > paq_pkg::BTN_A);
      mask[5] = mask[5] | (btn[1] && cfg.button_count > paq_pkg::BTN_B);
      mask[6] = mask[6] | (btn[4] && cfg.button_count > paq_pkg::BTN_L);
      mask[7] = mask[7] | (btn[5] && cfg.button_count > paq_pkg::BTN_R);
      mask[8] = mask[8] | (btn[7] && cfg.button_count > paq_pkg::BTN_START);
      mask[9] = mask[9] | (btn[6] && cfg.button_count > paq_pkg::BTN_SELECT);
    end
  end

  always_comb begin
    out_data_nxt = out_data_r;
    if (advance) begin
      out_data_nxt = {2'b00, dy, dx, mask};
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tvalid && in_tready) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: hold sample and result, no reset needed
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r <= in_tdata;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `PAQ_ASSERT_IMP(a_adv_needs_room, clk, rst_n, advance, !out_valid_r || out_tready)
  `PAQ_ASSERT_IMP(a_dir_only_when_eval, clk, rst_n, !eval_x, dx == paq_pkg::DIR_NONE)
  `PAQ_ASSERT_NXT(a_adv_gives_result, clk, rst_n, advance, out_valid_r)

endmodule

FILE: sim/pad_input_axis_qualifier_test.sv
`timescale 1ns / 1ps

module pad_input_axis_qualifier_test;

  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 8;     // extra wait once every result has arrived
  localparam int IDLE_LIMIT    = 4000;  // cycles with no transaction on either side
  localparam int ITEMS_PER_MODE = 52;

  // One poll sample as it sits in in_tdata, lowest field last
  typedef struct packed {
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_x;
    logic [7:0]         pad_buttons;
    logic [3:0]         hat_bits;
    logic [10:0]        key_states;
  } poll_sample_t;

  // One result as it sits in out_tdata[13:0]
  typedef struct packed {
    logic signed [1:0] dir_y;
    logic signed [1:0] dir_x;
    logic [9:0]        button_mask;
  } pad_report_t;

  logic                            clk;
  logic                            rst_n       = 1'b0;
  logic                            in_tvalid   = 1'b0;
  logic                            in_tready;
  logic [paq_pkg::IN_DATA_W-1:0]   in_tdata    = '0;
  logic                            out_tvalid;
  logic                            out_tready  = 1'b0;
  logic [paq_pkg::OUT_DATA_W-1:0]  out_tdata;
  logic                            cfg_psel    = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite  = 1'b0;
  logic [paq_pkg::CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [paq_pkg::CFG_DATA_W-1:0]  cfg_pwdata  = '0;
  logic [paq_pkg::CFG_DATA_W-1:0]  cfg_prdata;
  logic                            cfg_pready;

  pad_input_axis_qualifier dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: configuration and per-axis qualifier state, held in
  // step with every accepted input transaction.
  // ---------------------------------------------------------------------------
  paq_pkg::paq_cfg_t shadow_cfg = '{pad_present: 1'b0, axis_enable: 1'b0, axis_count: 2'd0,
                           button_count: 4'd0, hat_present: 1'b0,
                           center_limit: paq_pkg::CENTER_LIMIT_RST,
                           press_limit: paq_pkg::PRESS_LIMIT_RST,
                           release_limit: paq_pkg::RELEASE_LIMIT_RST};
  logic              axis_armed [2] = '{1'b0, 1'b0};
  logic signed [1:0] held_dir   [2] = '{paq_pkg::DIR_NONE, paq_pkg::DIR_NONE};
  logic signed [1:0] cand_dir   [2] = '{paq_pkg::DIR_NONE, paq_pkg::DIR_NONE};
  logic [1:0]        cand_count [2] = '{2'd0, 2'd0};

  pad_report_t expected_reports[$];
  int          mismatch_count = 0;

  // Stimulus shaping: each axis dwells in one zone for a few samples so that
  // the confirmation counter can actually reach its threshold.
  int axis_zone [2] = '{0, 0};
  int zone_left [2] = '{0, 0};

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  // Receiver hold-off: toggle to request a stretch, counted by the receiver
  logic hold_toggle = 1'b0;
  logic hold_seen   = 1'b0;
  int   hold_left   = 0;
  int   idle_cycles = 0;

  // Advance one axis: arm inside the centre band, then hysteresis on the held
  // direction and a change only after CONFIRM_COUNT_DEF equal proposals.
  function automatic logic signed [1:0] track_axis(int ax, int raw);
    int                c;
    int                p;
    int                r;
    logic signed [1:0] proposal;
    c = int'(shadow_cfg.center_limit);
    p = int'(shadow_cfg.press_limit);
    r = int'(shadow_cfg.release_limit);
    proposal = paq_pkg::DIR_NONE;
    if (!axis_armed[ax]) begin
      if (raw > -c && raw < c) begin
        axis_armed[ax] = 1'b1;
      end else begin
        // not centred yet: drop any pending state and report neutral
        held_dir[ax]   = paq_pkg::DIR_NONE;
        cand_dir[ax]   = paq_pkg::DIR_NONE;
        cand_count[ax] = 2'd0;
        return paq_pkg::DIR_NONE;
      end
    end
    if (held_dir[ax] == paq_pkg::DIR_NEG) begin
      proposal = (raw < -r) ? paq_pkg::DIR_NEG : paq_pkg::DIR_NONE;
    end else if (held_dir[ax] == paq_pkg::DIR_POS) begin
      proposal = (raw > r) ? paq_pkg::DIR_POS : paq_pkg::DIR_NONE;
    end else if (raw < -p) begin
      proposal = paq_pkg::DIR_NEG;
    end else if (raw > p) begin
      proposal = paq_pkg::DIR_POS;
    end
    if (proposal != held_dir[ax]) begin
      if (proposal == cand_dir[ax]) begin
        if (cand_count[ax] < 2'd3) cand_count[ax]++;
      end else begin
        cand_dir[ax]   = proposal;
        cand_count[ax] = 2'd1;
      end
      if (int'(cand_count[ax]) >= paq_pkg::CONFIRM_COUNT_DEF) begin
        held_dir[ax]   = proposal;
        cand_count[ax] = 2'd0;
      end
    end else begin
      cand_dir[ax]   = proposal;
      cand_count[ax] = 2'd0;
    end
    return held_dir[ax];
  endfunction

  function automatic logic button_held(logic [7:0] buttons, logic [3:0] idx);
    return (idx < shadow_cfg.button_count) && buttons[idx];
  endfunction

  // Work out the result of one poll sample and advance the shadow state
  function automatic pad_report_t predict_report(poll_sample_t s);
    pad_report_t res;
    res.dir_x = paq_pkg::DIR_NONE;
    res.dir_y = paq_pkg::DIR_NONE;
    res.button_mask = {|s.key_states[10:9], s.key_states[8], s.key_states[7:0]};
    if (shadow_cfg.pad_present) begin
      if (shadow_cfg.hat_present) res.button_mask[3:0] |= s.hat_bits;
      if (shadow_cfg.axis_enable) begin
        if (shadow_cfg.axis_count > 2'd0) res.dir_x = track_axis(0, int'(s.axis_x));
        if (shadow_cfg.axis_count > 2'd1) res.dir_y = track_axis(1, int'(s.axis_y));
        if (res.dir_x == paq_pkg::DIR_NEG) res.button_mask[0] = 1'b1;
        if (res.dir_x == paq_pkg::DIR_POS) res.button_mask[1] = 1'b1;
        if (res.dir_y == paq_pkg::DIR_NEG) res.button_mask[2] = 1'b1;
        if (res.dir_y == paq_pkg::DIR_POS) res.button_mask[3] = 1'b1;
      end
      res.button_mask[4] |= button_held(s.pad_buttons, paq_pkg::BTN_A);
      res.button_mask[5] |= button_held(s.pad_buttons, paq_pkg::BTN_B);
      res.button_mask[6] |= button_held(s.pad_buttons, paq_pkg::BTN_L);
      res.button_mask[7] |= button_held(s.pad_buttons, paq_pkg::BTN_R);
      res.button_mask[8] |= button_held(s.pad_buttons, paq_pkg::BTN_START);
      res.button_mask[9] |= button_held(s.pad_buttons, paq_pkg::BTN_SELECT);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic poll_sample_t make_poll(int keys, int hat, int btns, int x, int y);
    poll_sample_t s;
    s.key_states  = 11'(keys);
    s.hat_bits    = 4'(hat);
    s.pad_buttons = 8'(btns);
    s.axis_x      = 16'(x);
    s.axis_y      = 16'(y);
    return s;
  endfunction

  // Draw an axis sample from the zone that the axis currently dwells in,
  // placed relative to the live limits except in the fully random zone.
  function automatic int axis_sample(int ax);
    int c;
    int p;
    int r;
    int m;
    int lo;
    int hi;
    int base;
    logic neg;
    c = int'(shadow_cfg.center_limit);
    p = int'(shadow_cfg.press_limit);
    r = int'(shadow_cfg.release_limit);
    if (zone_left[ax] == 0) begin
      axis_zone[ax] = $urandom_range(9);
      zone_left[ax] = $urandom_range(4, 1);
    end
    zone_left[ax]--;
    neg = $urandom_range(1);
    lo  = (r < p) ? r : p;
    hi  = (r < p) ? p : r;
    case (axis_zone[ax])
      0, 1: m = (c == 0) ? 0 : $urandom_range(c - 1);
      2, 8: begin
        m = $urandom_range(32768, p + 1);
        neg = 1'b0;
      end
      3, 9: begin
        m = $urandom_range(32768, p + 1);
        neg = 1'b1;
      end
      4, 5: m = $urandom_range(hi, lo);
      6: begin
        case ($urandom_range(3))
          0: base = c;
          1: base = p;
          2: base = r;
          default: base = 32768;
        endcase
        m = base + $urandom_range(2) - 1;
        if (m < 0) m = 0;
      end
      default: return int'($signed(16'($urandom)));
    endcase
    if (neg) return (m > 32768) ? -32768 : -m;
    return (m > 32767) ? 32767 : m;
  endfunction

  function automatic poll_sample_t random_poll();
    return make_poll($urandom_range(2047), $urandom_range(15), $urandom_range(255),
                     axis_sample(0), axis_sample(1));
  endfunction

  // Offer one poll sample, idling first at the current rate, and record its
  // expected result once the transaction is accepted.
  task automatic send_poll(poll_sample_t s);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= paq_pkg::IN_DATA_W'({$urandom, $urandom});
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= paq_pkg::IN_DATA_W'(s);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_reports.push_back(predict_report(s));
  endtask

  // Hold the input quiet until every expected result has arrived
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup then access phase; psel stays high for back-to-back writes
  task automatic write_reg(paq_pkg::paq_reg_t idx, logic [paq_pkg::CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      paq_pkg::REG_PAD_PRESENT:   shadow_cfg.pad_present   = value[0];
      paq_pkg::REG_AXIS_ENABLE:   shadow_cfg.axis_enable   = value[0];
      paq_pkg::REG_AXIS_COUNT:    shadow_cfg.axis_count    = value[1:0];
      paq_pkg::REG_BUTTON_COUNT:  shadow_cfg.button_count  = value[3:0];
      paq_pkg::REG_HAT_PRESENT:   shadow_cfg.hat_present   = value[0];
      paq_pkg::REG_CENTER_LIMIT:  shadow_cfg.center_limit  = value[14:0];
      paq_pkg::REG_PRESS_LIMIT:   shadow_cfg.press_limit   = value[14:0];
      paq_pkg::REG_RELEASE_LIMIT: shadow_cfg.release_limit = value[14:0];
      default: ;
    endcase
  endtask

  // Drain the block, then rewrite every register
  task automatic apply_setting(paq_pkg::paq_cfg_t c);
    wait_drained();
    write_reg(paq_pkg::REG_PAD_PRESENT,   paq_pkg::CFG_DATA_W'(c.pad_present));
    write_reg(paq_pkg::REG_AXIS_ENABLE,   paq_pkg::CFG_DATA_W'(c.axis_enable));
    write_reg(paq_pkg::REG_AXIS_COUNT,    paq_pkg::CFG_DATA_W'(c.axis_count));
    write_reg(paq_pkg::REG_BUTTON_COUNT,  paq_pkg::CFG_DATA_W'(c.button_count));
    write_reg(paq_pkg::REG_HAT_PRESENT,   paq_pkg::CFG_DATA_W'(c.hat_present));
    write_reg(paq_pkg::REG_CENTER_LIMIT,  paq_pkg::CFG_DATA_W'(c.center_limit));
    write_reg(paq_pkg::REG_PRESS_LIMIT,   paq_pkg::CFG_DATA_W'(c.press_limit));
    write_reg(paq_pkg::REG_RELEASE_LIMIT, paq_pkg::CFG_DATA_W'(c.release_limit));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic paq_pkg::paq_cfg_t default_pad_setting();
    return '{pad_present: 1'b1, axis_enable: 1'b1, axis_count: 2'd2,
             button_count: 4'd8, hat_present: 1'b1,
             center_limit: paq_pkg::CENTER_LIMIT_RST,
             press_limit: paq_pkg::PRESS_LIMIT_RST,
             release_limit: paq_pkg::RELEASE_LIMIT_RST};
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(string what, int got, int want);
    mismatch_count++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic check_report(logic [paq_pkg::OUT_DATA_W-1:0] data);
    pad_report_t got;
    pad_report_t want;
    got = data[13:0];
    if (expected_reports.size() == 0) begin
      note_mismatch("result transaction with none expected", int'(data), 0);
    end else begin
      want = expected_reports.pop_front();
      if (got.button_mask != want.button_mask)
        note_mismatch("button_mask", int'(got.button_mask), int'(want.button_mask));
      if (got.dir_x != want.dir_x)
        note_mismatch("dir_x", int'(got.dir_x), int'(want.dir_x));
      if (got.dir_y != want.dir_y)
        note_mismatch("dir_y", int'(got.dir_y), int'(want.dir_y));
    end
  endtask

  // Receiver: check each accepted result, then stall at the current rate or
  // hold off for a long stretch when the test asks for one.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_report(out_tdata);
    if (hold_toggle != hold_seen) begin
      hold_seen  <= hold_toggle;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog: count cycles in which neither side moves a transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every mapping and the axis special cases
  task automatic test_directed();
    // pad absent after reset: only the keyboard reaches the mask
    send_poll(make_poll(0, 15, 255, 32767, -32768));
    send_poll(make_poll(2047, 0, 0, 0, 0));
    apply_setting(default_pad_setting());
    // axes not centred yet: full deflection must read neutral
    send_poll(make_poll(0, 15, 255, -32768, 32767));
    send_poll(make_poll(0, 0, 0, 0, 0));
    // armed: two equal proposals confirm a direction
    send_poll(make_poll(0, 0, 0, 32767, -32768));
    send_poll(make_poll(0, 0, 0, 32767, -32768));
    // inside the hysteresis band the held direction stays
    send_poll(make_poll(0, 0, 0, 20000, -20000));
    send_poll(make_poll(0, 0, 0, 20000, -20000));
    send_poll(make_poll(0, 0, 0, 0, 0));
    send_poll(make_poll(0, 0, 0, 0, 0));
    // alternating proposals never confirm
    send_poll(make_poll(0, 0, 0, 30000, -30000));
    send_poll(make_poll(0, 0, 0, -30000, 30000));
    send_poll(make_poll(0, 0, 0, 30000, -30000));
    send_poll(make_poll(0, 0, 0, 0, 0));
    send_poll(make_poll(0, 0, 0, 0, 0));
    // start, either shift as select
    send_poll(make_poll(11'h100, 0, 0, 0, 0));
    send_poll(make_poll(11'h200, 0, 0, 0, 0));
    send_poll(make_poll(11'h400, 0, 0, 0, 0));
    // pad buttons: A, B, L, R; then select and start; then unused ones
    send_poll(make_poll(0, 0, 8'h33, 0, 0));
    send_poll(make_poll(0, 0, 8'hC0, 0, 0));
    send_poll(make_poll(0, 0, 8'h0C, 0, 0));
    // exactly at the press limit proposes nothing; one beyond confirms
    send_poll(make_poll(0, 0, 0, 24000, -24000));
    send_poll(make_poll(0, 0, 0, 24001, -24001));
    send_poll(make_poll(0, 0, 0, 24001, -24001));
    // exactly at the release limit proposes neutral
    send_poll(make_poll(0, 0, 0, 18000, -18000));
  endtask

  // Random polls under several settings, each at every idling mix
  task automatic test_random_settings();
    paq_pkg::paq_cfg_t c;
    for (int which = 0; which < 7; which++) begin
      c = default_pad_setting();
      case (which)
        1: begin
          // odd limits: release above press, widest centre band
          c.axis_count    = 2'd3;
          c.button_count  = 4'd15;
          c.hat_present   = 1'b0;
          c.center_limit  = 15'd32767;
          c.press_limit   = 15'd0;
          c.release_limit = 15'd32767;
        end
        2: begin
          c.axis_count    = 2'd1;
          c.button_count  = 4'($urandom_range(8));
          c.center_limit  = 15'($urandom_range(32767));
          c.press_limit   = 15'($urandom_range(32767));
          c.release_limit = 15'($urandom_range(32767));
        end
        3: c.pad_present = 1'b0;
        4: begin
          c.axis_enable   = 1'b0;
          c.axis_count    = 2'd0;
          c.button_count  = 4'd4;
          c.center_limit  = 15'd0;
          c.press_limit   = 15'd32767;
          c.release_limit = 15'd0;
        end
        5: begin
          // only an exact zero arms; any deflection beyond one proposes
          c.button_count  = 4'd9;
          c.hat_present   = 1'b0;
          c.center_limit  = 15'd1;
          c.press_limit   = 15'd1;
          c.release_limit = 15'd0;
        end
        6: begin
          c.axis_count    = 2'd0;
          c.button_count  = 4'd0;
          c.center_limit  = 15'($urandom_range(32767));
          c.press_limit   = 15'($urandom_range(32767));
          c.release_limit = 15'($urandom_range(32767));
        end
        default: ;
      endcase
      apply_setting(c);
      for (int mode = 0; mode < 4; mode++) begin
        src_idle_pct   = (mode == 1) ? 64 : (mode == 3) ? 22 : 0;
        sink_stall_pct <= (mode == 2) ? 64 : (mode == 3) ? 22 : 0;
        for (int n = 0; n < ITEMS_PER_MODE; n++) send_poll(random_poll());
      end
    end
  endtask

  // Hold the receiver off so the block fills and stalls its input, then
  // pause the sender until everything has drained.
  task automatic test_backpressure();
    apply_setting(default_pad_setting());
    src_idle_pct   = 0;
    sink_stall_pct <= 0;
    hold_toggle    <= ~hold_toggle;
    for (int n = 0; n < 30; n++) send_poll(random_poll());
    wait_drained();
    for (int n = 0; n < 30; n++) send_poll(random_poll());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_settings();
    test_backpressure();
    wait_drained();
    if (expected_reports.size() != 0)
      note_mismatch("results never delivered", expected_reports.size(), 0);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
